### rtl/bsp_pkg.sv
// Shared types, constants and helpers for the byte-addressed operand stack.
package bsp_pkg;

  localparam int unsigned DEPTH_BYTES = 4096;
  localparam int unsigned ADDR_W      = $clog2(DEPTH_BYTES);
  localparam int unsigned LANES       = 8;
  localparam int unsigned LANE_W      = $clog2(LANES);
  localparam int unsigned ROW_W       = ADDR_W - LANE_W;
  localparam int unsigned BANK_ROWS   = DEPTH_BYTES / LANES;

  localparam int unsigned SP_W        = 13;
  localparam int unsigned LIMIT_W     = 13;
  localparam int unsigned VALUE_W     = 64;
  localparam int unsigned SIZE_CODE_W = 2;
  localparam int unsigned SIZE_W      = 4;
  localparam int unsigned STATUS_W    = 2;

  localparam int unsigned PADDR_W     = 2;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [PADDR_W-1:0] REG_STACK_LIMIT = PADDR_W'(0);
  localparam logic [LIMIT_W-1:0] LIMIT_RESET     = LIMIT_W'(4096);
  localparam logic [LIMIT_W-1:0] DEPTH_LIMIT     = LIMIT_W'(DEPTH_BYTES);

  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_e;

  // one access to the banked byte store
  typedef struct packed {
    logic                   en;
    logic                   we;
    logic [ADDR_W-1:0]      base;
    logic [SIZE_CODE_W-1:0] size_code;
    logic [VALUE_W-1:0]     wdata;
  } mem_req_t;

  function automatic logic [SIZE_W-1:0] size_bytes(input logic [SIZE_CODE_W-1:0] code);
    logic [SIZE_W-1:0] s;
    s = SIZE_W'(1) << code;
    return s;
  endfunction

endpackage

### rtl/bsp_if.sv
// Word channels of the operand stack: request in, result out.
interface bsp_in_if;
  logic                             valid;
  logic                             ready;
  logic                             opcode;
  logic [bsp_pkg::SIZE_CODE_W-1:0]  size_code;
  logic [bsp_pkg::VALUE_W-1:0]      push_value;

  modport source(output valid, opcode, size_code, push_value, input ready);
  modport sink(input valid, opcode, size_code, push_value, output ready);
endinterface

interface bsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [bsp_pkg::VALUE_W-1:0]   pop_value;
  logic [bsp_pkg::STATUS_W-1:0]  status;
  logic [bsp_pkg::SP_W-1:0]      depth_bytes;

  modport source(output valid, pop_value, status, depth_bytes, input ready);
  modport sink(input valid, pop_value, status, depth_bytes, output ready);
endinterface

### rtl/bsp_cfg_regs.sv
// APB-style register port holding the stack limit.
module bsp_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsp_pkg::PADDR_W-1:0]  paddr,
  input  logic [bsp_pkg::PDATA_W-1:0]  pwdata,
  output logic [bsp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output logic [bsp_pkg::LIMIT_W-1:0]  stack_limit_o
);

  logic [bsp_pkg::LIMIT_W-1:0] limit_q, limit_d;
  logic                        wr_hit;

  assign pready = 1'b1;
  assign wr_hit = psel & penable & pwrite & (paddr == bsp_pkg::REG_STACK_LIMIT);

  always_comb begin
    limit_d = limit_q;
    if (wr_hit) begin
      limit_d = pwdata[bsp_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= bsp_pkg::LIMIT_RESET;
    end else begin
      limit_q <= limit_d;
    end
  end

  always_comb begin
    unique case (paddr)
      bsp_pkg::REG_STACK_LIMIT: prdata = bsp_pkg::PDATA_W'(limit_q);
      default:                  prdata = '0;
    endcase
  end

  assign stack_limit_o = limit_q;

endmodule

### rtl/bsp_lane_mem.sv
// Byte store split into eight byte-lane banks; unaligned access rotates lanes.
module bsp_lane_mem (
  input  logic                         clk_i,
  input  bsp_pkg::mem_req_t            req_i,
  output logic [bsp_pkg::VALUE_W-1:0]  rdata_o
);

  localparam int unsigned LW = bsp_pkg::LANE_W;
  localparam int unsigned RW = bsp_pkg::ROW_W;

  logic [bsp_pkg::SIZE_W-1:0]       req_size;
  logic [7:0]                       lane_rd_q [bsp_pkg::LANES];
  logic [LW-1:0]                    rot_q;
  logic [bsp_pkg::SIZE_CODE_W-1:0]  rd_size_code_q;

  assign req_size = bsp_pkg::size_bytes(req_i.size_code);

  for (genvar k = 0; k < bsp_pkg::LANES; k++) begin : g_lane
    logic [7:0]    bank_q [bsp_pkg::BANK_ROWS];
    logic [LW-1:0] offset;
    logic [RW-1:0] row;
    logic          lane_en;
    logic [7:0]    wbyte;

    always_comb begin
      // byte index within the word that lands on this lane
      offset  = LW'(k) - req_i.base[LW-1:0];
      // lanes below the start lane wrap into the next row
      row     = req_i.base[bsp_pkg::ADDR_W-1:LW]
                + RW'(LW'(k) < req_i.base[LW-1:0]);
      lane_en = {1'b0, offset} < req_size;
      wbyte   = req_i.wdata[8*offset +: 8];
    end

    always_ff @(posedge clk_i) begin
      if (req_i.en && req_i.we && lane_en) begin
        bank_q[row] <= wbyte;
      end
      if (req_i.en && !req_i.we) begin
        lane_rd_q[k] <= bank_q[row];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.en && !req_i.we) begin
      rot_q          <= req_i.base[LW-1:0];
      rd_size_code_q <= req_i.size_code;
    end
  end

  always_comb begin
    logic [bsp_pkg::SIZE_W-1:0] rd_size;
    logic [LW-1:0]              lane;
    rd_size = bsp_pkg::size_bytes(rd_size_code_q);
    rdata_o = '0;
    for (int j = 0; j < bsp_pkg::LANES; j++) begin
      lane = rot_q + LW'(j);
      if (bsp_pkg::SIZE_W'(j) < rd_size) begin
        rdata_o[8*j +: 8] = lane_rd_q[lane];
      end
    end
  end

endmodule

### rtl/byte_stack_push_pop.sv
// Top level of the byte-addressed operand stack (push/pop 1, 2, 4 or 8 bytes).
// A taken request word moves the FSM to S_RESP, where the result is registered into
// the single output register once that is free. A new word is taken only in S_IDLE, so
// one word is done before the next is taken; a result that waits holds off the next.
// Reset: pointer 0, limit 4096, output empty; store contents undefined.
module byte_stack_push_pop (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  bsp_in_if.sink                       in_i,
  bsp_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bsp_pkg::PADDR_W-1:0]  paddr,
  input  logic [bsp_pkg::PDATA_W-1:0]  pwdata,
  output logic [bsp_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  typedef enum logic {S_IDLE, S_RESP} state_e;

  localparam int unsigned SW = bsp_pkg::SP_W;

  state_e                          state_q, state_d;
  logic [SW-1:0]                   sp_q, sp_d;
  logic                            out_valid_q, out_valid_d;
  logic [bsp_pkg::VALUE_W-1:0]     pop_value_q, pop_value_d;
  bsp_pkg::status_e                status_q, status_d;
  logic [SW-1:0]                   depth_q, depth_d;
  bsp_pkg::status_e                pend_status_q, pend_status_d;
  logic                            pend_rd_q, pend_rd_d;

  logic [bsp_pkg::LIMIT_W-1:0]     stack_limit;
  logic [bsp_pkg::LIMIT_W-1:0]     eff_limit;
  logic [bsp_pkg::SIZE_W-1:0]      size;
  logic [SW:0]                     push_end;
  logic [SW-1:0]                   pop_base;
  logic                            is_pop, ovf, unf, item_ok, in_fire, out_load;
  bsp_pkg::mem_req_t               mem_req;
  logic [bsp_pkg::VALUE_W-1:0]     mem_rdata;

  bsp_cfg_regs u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .stack_limit_o (stack_limit)
  );

  bsp_lane_mem u_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (mem_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid & in_i.ready;

  always_comb begin
    eff_limit = (stack_limit > bsp_pkg::DEPTH_LIMIT) ? bsp_pkg::DEPTH_LIMIT : stack_limit;
    size      = bsp_pkg::size_bytes(in_i.size_code);
    is_pop    = (in_i.opcode == bsp_pkg::OP_POP);
    push_end  = {1'b0, sp_q} + (SW + 1)'(size);
    pop_base  = sp_q - SW'(size);
    // one-byte pushes obey the same limit rule, so usable room is limit - 1
    ovf       = !is_pop && (push_end >= (SW + 1)'(eff_limit));
    unf       = is_pop && (sp_q < SW'(size));
    item_ok   = !ovf && !unf;

    mem_req.en        = in_fire && item_ok;
    mem_req.we        = !is_pop;
    mem_req.base      = is_pop ? pop_base[bsp_pkg::ADDR_W-1:0] : sp_q[bsp_pkg::ADDR_W-1:0];
    mem_req.size_code = in_i.size_code;
    mem_req.wdata     = in_i.push_value;
  end

  assign out_load = (state_q == S_RESP) && (!out_valid_q || out_o.ready);

  always_comb begin
    state_d       = state_q;
    sp_d          = sp_q;
    out_valid_d   = out_valid_q;
    pop_value_d   = pop_value_q;
    status_d      = status_q;
    depth_d       = depth_q;
    pend_status_d = pend_status_q;
    pend_rd_d     = pend_rd_q;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          state_d   = S_RESP;
          pend_rd_d = is_pop && item_ok;
          if (ovf) begin
            pend_status_d = bsp_pkg::ST_OVERFLOW;
          end else if (unf) begin
            pend_status_d = bsp_pkg::ST_UNDERFLOW;
          end else begin
            pend_status_d = bsp_pkg::ST_OK;
            sp_d          = is_pop ? pop_base : push_end[SW-1:0];
          end
        end
      end
      S_RESP: begin
        // read data stays put until the next access, so waiting here is safe
        if (out_load) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          pop_value_d = pend_rd_q ? mem_rdata : '0;
          status_d    = pend_status_q;
          depth_d     = sp_q;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      sp_q          <= '0;
      out_valid_q   <= 1'b0;
      pend_rd_q     <= 1'b0;
      pend_status_q <= bsp_pkg::ST_OK;
      status_q      <= bsp_pkg::ST_OK;
      pop_value_q   <= '0;
      depth_q       <= '0;
    end else begin
      state_q       <= state_d;
      sp_q          <= sp_d;
      out_valid_q   <= out_valid_d;
      pend_rd_q     <= pend_rd_d;
      pend_status_q <= pend_status_d;
      status_q      <= status_d;
      pop_value_q   <= pop_value_d;
      depth_q       <= depth_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.pop_value   = pop_value_q;
  assign out_o.status      = status_q;
  assign out_o.depth_bytes = depth_q;

  a_sp_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SW'(bsp_pkg::DEPTH_BYTES))
    else $error("stack pointer beyond store");

  a_interlock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_i.ready)
    else $error("word taken while previous access in flight");

  a_refused_holds_sp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !item_ok |=> $stable(sp_q))
    else $error("refused word moved the pointer");

  a_push_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && item_ok && !is_pop |=> sp_q > $past(sp_q))
    else $error("accepted push did not advance the pointer");

endmodule

### bench/tb_byte_stack_push_pop.sv
// Testbench for byte_stack_push_pop: random push/pop words, stalls, limit changes over APB.
module tb_byte_stack_push_pop;
  timeunit 1ns;
  timeprecision 1ps;

  import bsp_pkg::*;

  localparam logic [SIZE_CODE_W-1:0] SZ_1B = 2'd0;
  localparam logic [SIZE_CODE_W-1:0] SZ_2B = 2'd1;
  localparam logic [SIZE_CODE_W-1:0] SZ_4B = 2'd2;
  localparam logic [SIZE_CODE_W-1:0] SZ_8B = 2'd3;

  typedef struct {
    logic                   opcode;
    logic [SIZE_CODE_W-1:0] size_code;
    logic [VALUE_W-1:0]     push_value;
  } stack_op_t;

  typedef struct {
    logic [VALUE_W-1:0] pop_value;
    status_e            status;
    logic [SP_W-1:0]    depth;
  } stack_res_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic pready;

  bsp_in_if  in_if ();
  bsp_out_if out_if ();

  byte_stack_push_pop dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow of the block
  bit [7:0]         store_q [DEPTH_BYTES];
  int unsigned      sp_q;
  logic [LIMIT_W-1:0] limit_q;
  stack_res_t       results_due[$];

  stack_op_t   op_queue[$];
  stack_op_t   on_bus;
  int unsigned gen_sp;
  int unsigned items_queued;
  int unsigned accepted_cnt;
  int unsigned results_checked;
  int unsigned errors;
  int unsigned n_push_ok, n_pop_ok, n_overflow, n_underflow, peak_sp, n_limits;

  always begin
    clk_i = 1'b1;
    #6;
    clk_i = 1'b0;
    #6;
  end

  function automatic bit calm();
    return accepted_cnt >= 400 && accepted_cnt < 700;
  endfunction

  function automatic int unsigned usable_limit();
    return (limit_q > DEPTH_BYTES) ? DEPTH_BYTES : limit_q;
  endfunction

  task automatic flag_mismatch(input string msg);
    errors++;
    $display("%0t mismatch: %s", $realtime, msg);
  endtask

  function automatic void apply_stack_op(input stack_op_t op);
    stack_res_t  r;
    int unsigned nbytes;
    int unsigned base;
    nbytes = 1 << op.size_code;
    r.pop_value = '0;
    r.status = ST_OK;
    if (op.opcode == OP_PUSH) begin
      if (sp_q + nbytes >= usable_limit()) begin
        r.status = ST_OVERFLOW;
        n_overflow++;
      end else begin
        for (int i = 0; i < nbytes; i++) store_q[sp_q + i] = op.push_value[8*i +: 8];
        sp_q += nbytes;
        n_push_ok++;
      end
    end else if (sp_q < nbytes) begin
      r.status = ST_UNDERFLOW;
      n_underflow++;
    end else begin
      base = sp_q - nbytes;
      for (int i = 0; i < nbytes; i++) r.pop_value[8*i +: 8] = store_q[base + i];
      sp_q = base;
      n_pop_ok++;
    end
    if (sp_q > peak_sp) peak_sp = sp_q;
    r.depth = SP_W'(sp_q);
    results_due.push_back(r);
  endfunction

  // Queues a word and tracks the pointer it will leave; returns 1 if it will be refused.
  function automatic bit queue_op(input logic opc, input logic [SIZE_CODE_W-1:0] sc,
                                  input logic [VALUE_W-1:0] v);
    stack_op_t   op;
    int unsigned nbytes;
    bit          refused;
    nbytes = 1 << sc;
    op.opcode = opc;
    op.size_code = sc;
    op.push_value = v;
    op_queue.push_back(op);
    items_queued++;
    if (opc == OP_PUSH) begin
      refused = (gen_sp + nbytes >= usable_limit());
      if (!refused) gen_sp += nbytes;
    end else begin
      refused = (gen_sp < nbytes);
      if (!refused) gen_sp -= nbytes;
    end
    return refused;
  endfunction

  // driver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_if.valid && in_if.ready) begin
        apply_stack_op(on_bus);
        accepted_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (op_queue.size() > 0 && (calm() || $urandom_range(99) >= 36)) begin
          on_bus = op_queue.pop_front();
          in_if.valid      <= 1'b1;
          in_if.opcode     <= on_bus.opcode;
          in_if.size_code  <= on_bus.size_code;
          in_if.push_value <= on_bus.push_value;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk_i) begin
    stack_res_t due;
    out_if.ready <= calm() || ($urandom_range(99) >= 36);
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_checked++;
      if (results_due.size() == 0) begin
        flag_mismatch("result word with nothing expected");
      end else begin
        due = results_due.pop_front();
        if (out_if.pop_value !== due.pop_value)
          flag_mismatch($sformatf("pop_value %h, expected %h", out_if.pop_value,
                                  due.pop_value));
        if (out_if.status !== due.status)
          flag_mismatch($sformatf("status %0d, expected %s", out_if.status,
                                  due.status.name()));
        if (out_if.depth_bytes !== due.depth)
          flag_mismatch($sformatf("depth_bytes %0d, expected %0d", out_if.depth_bytes,
                                  due.depth));
      end
    end
  end

  task automatic drain();
    while (results_checked != items_queued) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // write the limit, then read it back
  task automatic write_stack_limit(input logic [LIMIT_W-1:0] v);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_STACK_LIMIT;
    pwdata  <= PDATA_W'(v);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    limit_q = v;
    n_limits++;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    if (prdata !== PDATA_W'(v))
      flag_mismatch($sformatf("stack_limit reads %0d, written %0d", prdata, v));
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic random_walk(input int count, input int big_pct);
    bit                     rising;
    logic                   opc;
    logic [SIZE_CODE_W-1:0] sc;
    rising = 1'b1;
    repeat (count) begin
      opc = ($urandom_range(99) < (rising ? 90 : 10)) ? OP_PUSH : OP_POP;
      sc = ($urandom_range(99) < big_pct) ? SZ_8B : SIZE_CODE_W'($urandom_range(3));
      // turn around at whichever end refuses
      if (queue_op(opc, sc, {$urandom, $urandom})) rising = (opc == OP_POP);
    end
  endtask

  task automatic limit_phase(input logic [LIMIT_W-1:0] lim, input int count,
                             input int big_pct);
    drain();
    write_stack_limit(lim);
    random_walk(count, big_pct);
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.opcode = OP_PUSH;
    in_if.size_code = SZ_1B;
    in_if.push_value = '0;
    out_if.ready = 1'b0;
    sp_q = 0;
    gen_sp = 0;
    limit_q = LIMIT_RESET;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty stack: every size underflows
    void'(queue_op(OP_POP, SZ_1B, '0));
    void'(queue_op(OP_POP, SZ_2B, '0));
    void'(queue_op(OP_POP, SZ_4B, '0));
    void'(queue_op(OP_POP, SZ_8B, '0));
    // misaligned pushes, pops that straddle earlier pushes
    void'(queue_op(OP_PUSH, SZ_1B, 64'h0000_0000_0000_00a5));
    void'(queue_op(OP_PUSH, SZ_8B, 64'hffff_ffff_ffff_ffff));
    void'(queue_op(OP_PUSH, SZ_2B, 64'hffff_ffff_ffff_0000));
    void'(queue_op(OP_PUSH, SZ_4B, 64'h0123_4567_89ab_cdef));
    void'(queue_op(OP_POP, SZ_8B, '1));
    void'(queue_op(OP_POP, SZ_8B, '0));
    void'(queue_op(OP_POP, SZ_4B, '0));
    void'(queue_op(OP_POP, SZ_2B, '0));
    void'(queue_op(OP_POP, SZ_1B, '0));
    void'(queue_op(OP_POP, SZ_1B, '0));

    // small limit: usable capacity is limit minus one
    drain();
    write_stack_limit(LIMIT_W'(16));
    void'(queue_op(OP_PUSH, SZ_8B, '0));
    void'(queue_op(OP_PUSH, SZ_4B, 64'h8000_0000_dead_beef));
    void'(queue_op(OP_PUSH, SZ_2B, 64'h5a5a));
    void'(queue_op(OP_PUSH, SZ_1B, 64'h7e));
    void'(queue_op(OP_PUSH, SZ_1B, 64'h81));
    void'(queue_op(OP_PUSH, SZ_8B, '1));
    // limit dropped under the pointer: pushes refused, pops still work
    drain();
    write_stack_limit(LIMIT_W'(4));
    void'(queue_op(OP_PUSH, SZ_1B, 64'h11));
    void'(queue_op(OP_POP, SZ_1B, '0));
    drain();
    write_stack_limit('0);
    void'(queue_op(OP_PUSH, SZ_1B, 64'h22));
    void'(queue_op(OP_POP, SZ_2B, '0));
    drain();
    write_stack_limit(LIMIT_W'(1));
    void'(queue_op(OP_PUSH, SZ_1B, 64'h33));

    // limit above the store size runs the stack up to the top
    limit_phase('1, 1000, 70);
    limit_phase(LIMIT_W'(DEPTH_BYTES), 250, 50);
    limit_phase(LIMIT_W'($urandom_range(300, 2)), 200, 25);
    limit_phase(LIMIT_W'(1), 60, 25);
    limit_phase('0, 60, 25);
    limit_phase(LIMIT_W'($urandom_range(300, 2)), 200, 25);
    limit_phase(LIMIT_W'(DEPTH_BYTES - 1), 200, 60);
    drain();
    repeat (8) @(posedge clk_i);

    $display("checked %0d words: %0d pushes, %0d pops, %0d overflows, %0d underflows",
             results_checked, n_push_ok, n_pop_ok, n_overflow, n_underflow);
    $display("deepest stack %0d bytes over %0d limit settings", peak_sp, n_limits);
    if (errors == 0 && results_due.size() == 0) begin
      $display("tb_byte_stack_push_pop OK");
    end else begin
      $display("tb_byte_stack_push_pop NOT OK");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d words still expected", results_due.size());
    $display("tb_byte_stack_push_pop NOT OK");
    $finish;
  end

endmodule

### filelist.f
rtl/bsp_pkg.sv
rtl/bsp_if.sv
rtl/bsp_cfg_regs.sv
rtl/bsp_lane_mem.sv
rtl/byte_stack_push_pop.sv
bench/tb_byte_stack_push_pop.sv
